FILE: src/els_pkg.sv
// Package for the LOOK elevator scheduler: command, report and motion codes,
// the result record and default sizing. No dependencies.
package els_pkg;

    // Default number of floors served by the car
    localparam int NumFloorsDefault = 10;

    // Fixed field widths of the streams
    localparam int CmdW   = 2;
    localparam int FloorW = 4;
    localparam int KindW  = 2;
    localparam int MotW   = 2;

    // Command carried with each input item
    typedef enum logic [CmdW-1:0] {
        CMD_TICK    = 2'd0,
        CMD_REQUEST = 2'd1,
        CMD_BOARD   = 2'd2,
        CMD_ALIGHT  = 2'd3
    } cmd_t;

    // Kind of a result item
    typedef enum logic [KindW-1:0] {
        KIND_TICK   = 2'd0,
        KIND_BOARD  = 2'd1,
        KIND_ALIGHT = 2'd2
    } kind_t;

    // Travel direction; SERVED only ever appears in a report
    typedef enum logic [MotW-1:0] {
        MOT_DOWN   = 2'd0,
        MOT_IDLE   = 2'd1,
        MOT_UP     = 2'd2,
        MOT_SERVED = 2'd3
    } motion_t;

    // One result item plus its presence flag
    typedef struct packed {
        logic              valid;
        kind_t             kind;
        motion_t           motion;
        logic [FloorW-1:0] car_floor;
    } result_t;

endpackage

FILE: src/elevator_look_scheduler.sv
// Top level of the LOOK elevator scheduler: input register, car state and
// result register around els_step. Depends on els_pkg and els_step.
//
//  Channel  | Dir | tuser            | tdata
//  s_axis   | in  | [1:0] command    | [3:0] floor_number, [7:4] zero
//  m_axis   | out | [1:0] report_kind| [1:0] motion, [5:2] car_floor, [7:6] zero
//
// One item per cycle while the result side does not stall. An item's state
// update and report are formed from the input register and captured in the
// result register as it advances, raising m_axis_tvalid if it has a report.
// Reset: pending requests clear, car at floor one, direction up; both
// stages empty. A stalled result holds the input stage, and a full input
// stage that cannot move drops s_axis_tready.
module elevator_look_scheduler #(
    parameter int NUM_FLOORS = els_pkg::NumFloorsDefault
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [3:0] floor_number
    input  logic [1:0] s_axis_tuser,   // [1:0] command
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [1:0] motion, [5:2] car_floor
    output logic [1:0] m_axis_tuser    // [1:0] report_kind
);

    localparam int PosW = $clog2(NUM_FLOORS + 1);

    // input stage
    logic                          in_valid_reg;
    els_pkg::cmd_t                 in_cmd_reg;
    logic [els_pkg::FloorW-1:0]    in_floor_reg;
    logic                          advance;

    // car state
    logic [NUM_FLOORS-1:0]         pend_reg;
    logic [NUM_FLOORS-1:0]         pend_next;
    logic [PosW-1:0]               pos_reg;
    logic [PosW-1:0]               pos_next;
    els_pkg::motion_t              dir_reg;
    els_pkg::motion_t              dir_next;

    // result stage
    els_pkg::result_t              res;
    logic                          out_valid_reg;
    els_pkg::result_t              out_reg;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            in_cmd_reg   <= els_pkg::cmd_t'(s_axis_tuser);
            in_floor_reg <= s_axis_tdata[els_pkg::FloorW-1:0];
        end
    end

    els_step #(
        .NUM_FLOORS (NUM_FLOORS),
        .PosW       (PosW)
    ) u_step (
        .cmd       (in_cmd_reg),
        .floor_num (in_floor_reg),
        .pend      (pend_reg),
        .pos       (pos_reg),
        .dir       (dir_reg),
        .pend_next (pend_next),
        .pos_next  (pos_next),
        .dir_next  (dir_next),
        .res       (res)
    );

    // Car state, updated as the item leaves the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            pos_reg  <= PosW'(1);
            dir_reg  <= els_pkg::MOT_UP;
        end else if (advance) begin
            pend_reg <= pend_next;
            pos_reg  <= pos_next;
            dir_reg  <= dir_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res.valid;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {2'b00, out_reg.car_floor, out_reg.motion};

    // Car never leaves the served floors
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(pos_reg) >= 1) && (int'(pos_reg) <= NUM_FLOORS))
        else $error("car position out of range");

    // Direction register never holds the served code
    a_dir_code: assert property (@(posedge aclk) disable iff (!aresetn)
        dir_reg != els_pkg::MOT_SERVED)
        else $error("direction register holds served code");

    // Every tick yields a result
    a_tick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd_reg == els_pkg::CMD_TICK) |=> m_axis_tvalid)
        else $error("tick without result");

    // A floor request never yields a result
    a_req_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd_reg == els_pkg::CMD_REQUEST) |=> !m_axis_tvalid)
        else $error("request produced a result");

    // With nothing pending a tick reports idle
    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd_reg == els_pkg::CMD_TICK && pend_reg == '0)
        |=> (m_axis_tdata[1:0] == els_pkg::MOT_IDLE))
        else $error("empty tick not idle");

endmodule

FILE: src/els_step.sv
// Single-pass next-state and report logic of the LOOK scheduler.
// Depends on els_pkg for codes and the result record.
module els_step #(
    parameter int NUM_FLOORS = els_pkg::NumFloorsDefault,
    parameter int PosW       = $clog2(NUM_FLOORS + 1)
) (
    input  els_pkg::cmd_t                cmd,
    input  logic [els_pkg::FloorW-1:0]   floor_num,
    input  logic [NUM_FLOORS-1:0]        pend,
    input  logic [PosW-1:0]              pos,
    input  els_pkg::motion_t             dir,
    output logic [NUM_FLOORS-1:0]        pend_next,
    output logic [PosW-1:0]              pos_next,
    output els_pkg::motion_t             dir_next,
    output els_pkg::result_t             res
);

    logic [NUM_FLOORS-1:0] above_mask;
    logic [NUM_FLOORS-1:0] below_mask;
    logic [NUM_FLOORS-1:0] floor_hot;
    logic [NUM_FLOORS-1:0] moved_hot;
    logic                  any_up;
    logic                  any_down;
    logic                  floor_ok;
    logic                  at_car;
    logic                  served;
    els_pkg::motion_t      tick_dir;
    logic [PosW-1:0]       tick_pos;

    // Per-floor masks: floors above / below the car, the named floor
    always_comb begin
        for (int i = 0; i < NUM_FLOORS; i++) begin
            above_mask[i] = (i >= int'(pos));
            below_mask[i] = (i + 1 < int'(pos));
            floor_hot[i]  = (int'(floor_num) == i + 1);
        end
    end

    assign any_up   = |(pend & above_mask);
    assign any_down = |(pend & below_mask);
    assign floor_ok = (floor_num != '0) && (int'(floor_num) <= NUM_FLOORS);
    assign at_car   = floor_ok && (int'(floor_num) == int'(pos));

    // LOOK direction choice
    always_comb begin
        tick_dir = dir;
        if (pend == '0) begin
            tick_dir = els_pkg::MOT_IDLE;
        end else if (dir == els_pkg::MOT_UP) begin
            if (!any_up) tick_dir = any_down ? els_pkg::MOT_DOWN : els_pkg::MOT_IDLE;
        end else if (dir == els_pkg::MOT_DOWN) begin
            if (!any_down) tick_dir = any_up ? els_pkg::MOT_UP : els_pkg::MOT_IDLE;
        end else begin
            if (any_up) tick_dir = els_pkg::MOT_UP;
            else if (any_down) tick_dir = els_pkg::MOT_DOWN;
        end
    end

    // One floor of travel, then check the arrival floor
    always_comb begin
        tick_pos = pos;
        if (tick_dir == els_pkg::MOT_UP && int'(pos) < NUM_FLOORS) begin
            tick_pos = pos + PosW'(1);
        end else if (tick_dir == els_pkg::MOT_DOWN && int'(pos) > 1) begin
            tick_pos = pos - PosW'(1);
        end
        for (int i = 0; i < NUM_FLOORS; i++) begin
            moved_hot[i] = (int'(tick_pos) == i + 1);
        end
    end

    assign served = |(pend & moved_hot);

    // Per-command state update and report
    always_comb begin
        pend_next     = pend;
        pos_next      = pos;
        dir_next      = dir;
        res.valid     = 1'b0;
        res.kind      = els_pkg::KIND_TICK;
        res.motion    = dir;
        res.car_floor = els_pkg::FloorW'(pos);
        case (cmd)
            els_pkg::CMD_TICK: begin
                dir_next      = tick_dir;
                pos_next      = tick_pos;
                pend_next     = served ? (pend & ~moved_hot) : pend;
                res.valid     = 1'b1;
                res.motion    = served ? els_pkg::MOT_SERVED : tick_dir;
                res.car_floor = els_pkg::FloorW'(tick_pos);
            end
            els_pkg::CMD_REQUEST: begin
                if (floor_ok) pend_next = pend | floor_hot;
            end
            default: begin
                // board or alight at the car's floor
                if (at_car) begin
                    pend_next = pend & ~floor_hot;
                    res.valid = 1'b1;
                    res.kind  = (cmd == els_pkg::CMD_BOARD) ?
                                els_pkg::KIND_BOARD : els_pkg::KIND_ALIGHT;
                end
            end
        endcase
    end

endmodule

FILE: test/tb_elevator_look_scheduler.sv
`timescale 1ns / 1ps
// Testbench for elevator_look_scheduler: a LOOK car predictor in a small scoreboard
// class, stream drivers with random idle bursts, and a report checker.
// Depends on els_pkg and the elevator_look_scheduler RTL.

// Tracks pending floor calls, the car's floor and heading, and holds the
// reports the car should produce, oldest first.
class look_scoreboard;
    typedef struct packed {
        els_pkg::kind_t   kind;
        els_pkg::motion_t motion;
        logic [3:0]       car_floor;
    } report_t;

    logic [els_pkg::NumFloorsDefault-1:0] calls;
    logic [3:0]                           car_at;
    els_pkg::motion_t                     heading;
    report_t                              reports[$];
    int                                   mismatches;
    int                                   checked;

    function new();
        calls      = '0;
        car_at     = 4'd1;
        heading    = els_pkg::MOT_UP;
        mismatches = 0;
        checked    = 0;
    endfunction

    // Apply one accepted command to the car and queue the report it causes
    function void note_command(els_pkg::cmd_t cmd, logic [3:0] floor);
        bit      up;
        bit      down;
        int      f;
        report_t r;
        up   = 1'b0;
        down = 1'b0;
        case (cmd)
            els_pkg::CMD_TICK: begin
                for (f = 1; f <= els_pkg::NumFloorsDefault; f++) begin
                    if (calls[f-1]) begin
                        if (f > car_at) up = 1'b1;
                        if (f < car_at) down = 1'b1;
                    end
                end
                // LOOK: keep heading while calls lie ahead, else turn or rest
                if (calls == '0) begin
                    heading = els_pkg::MOT_IDLE;
                end else if (heading == els_pkg::MOT_UP) begin
                    if (!up) heading = down ? els_pkg::MOT_DOWN : els_pkg::MOT_IDLE;
                end else if (heading == els_pkg::MOT_DOWN) begin
                    if (!down) heading = up ? els_pkg::MOT_UP : els_pkg::MOT_IDLE;
                end else begin
                    if (up) heading = els_pkg::MOT_UP;
                    else if (down) heading = els_pkg::MOT_DOWN;
                end
                if (heading == els_pkg::MOT_UP && car_at < els_pkg::NumFloorsDefault)
                    car_at++;
                else if (heading == els_pkg::MOT_DOWN && car_at > 1)
                    car_at--;
                r.kind      = els_pkg::KIND_TICK;
                r.motion    = heading;
                r.car_floor = car_at;
                if (calls[car_at-1]) begin
                    calls[car_at-1] = 1'b0;
                    r.motion = els_pkg::MOT_SERVED;
                end
                reports.push_back(r);
            end
            els_pkg::CMD_REQUEST: begin
                if (floor >= 1 && floor <= els_pkg::NumFloorsDefault)
                    calls[floor-1] = 1'b1;
            end
            default: begin
                // boarding or alighting only counts at the car's own floor
                if (floor >= 1 && floor <= els_pkg::NumFloorsDefault && floor == car_at) begin
                    calls[floor-1] = 1'b0;
                    r.kind      = (cmd == els_pkg::CMD_BOARD) ?
                                  els_pkg::KIND_BOARD : els_pkg::KIND_ALIGHT;
                    r.motion    = heading;
                    r.car_floor = car_at;
                    reports.push_back(r);
                end
            end
        endcase
    endfunction

    // Compare one result transaction with the oldest queued report
    function void check_report(els_pkg::kind_t kind, els_pkg::motion_t motion,
                               logic [3:0] car_floor);
        report_t r;
        if (reports.size() == 0) begin
            $error("unexpected report: kind %0d motion %0d floor %0d", kind, motion, car_floor);
            mismatches++;
        end else begin
            r = reports.pop_front();
            checked++;
            if (kind !== r.kind) begin
                $error("report_kind: expected %0d, got %0d", r.kind, kind);
                mismatches++;
            end
            if (motion !== r.motion) begin
                $error("motion: expected %0d, got %0d", r.motion, motion);
                mismatches++;
            end
            if (car_floor !== r.car_floor) begin
                $error("car_floor: expected %0d, got %0d", r.car_floor, car_floor);
                mismatches++;
            end
        end
    endfunction
endclass

module tb_elevator_look_scheduler;

    localparam int CycleLimit = 400000;
    localparam int RandomGoal = 1550;
    localparam int QuietTail  = 200;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [3:0] floor_number
    logic [1:0] s_axis_tuser  = 2'b00;   // [1:0] command
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b1;
    logic [7:0] m_axis_tdata;            // [1:0] motion, [5:2] car_floor
    logic [1:0] m_axis_tuser;            // [1:0] report_kind

    look_scoreboard car_board = new();
    bit             idle_on   = 1'b1;
    int             cycles    = 0;
    int             directed_count = 0;
    int             random_count   = 0;

    elevator_look_scheduler DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: check every accepted transaction
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            car_board.check_report(els_pkg::kind_t'(m_axis_tuser),
                                   els_pkg::motion_t'(m_axis_tdata[1:0]),
                                   m_axis_tdata[5:2]);
    end

    // Result side back-pressure in random bursts
    initial begin
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Present one command, wait for its transaction, then maybe go idle
    task automatic send_command(input els_pkg::cmd_t cmd, input logic [3:0] floor);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0000, floor};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        car_board.note_command(cmd, floor);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    // Directed: idle rest, out-of-range calls, acks at and away from the car,
    // a call at the car's own floor, a full run to the top and a reversal
    task automatic run_directed();
        send_command(els_pkg::CMD_TICK,    4'd0);
        send_command(els_pkg::CMD_REQUEST, 4'd0);
        send_command(els_pkg::CMD_REQUEST, 4'd15);
        send_command(els_pkg::CMD_REQUEST, 4'd11);
        send_command(els_pkg::CMD_BOARD,   4'd1);
        send_command(els_pkg::CMD_ALIGHT,  4'd2);
        send_command(els_pkg::CMD_REQUEST, 4'd10);
        send_command(els_pkg::CMD_REQUEST, 4'd1);
        send_command(els_pkg::CMD_REQUEST, 4'd5);
        repeat (4) send_command(els_pkg::CMD_TICK, 4'd15);
        send_command(els_pkg::CMD_ALIGHT,  4'd5);
        send_command(els_pkg::CMD_BOARD,   4'd7);
        repeat (5) send_command(els_pkg::CMD_TICK, 4'd0);
        send_command(els_pkg::CMD_BOARD,   4'd10);
        send_command(els_pkg::CMD_ALIGHT,  4'd0);
        send_command(els_pkg::CMD_TICK,    4'd9);
        send_command(els_pkg::CMD_REQUEST, 4'd9);
        send_command(els_pkg::CMD_TICK,    4'd0);
        directed_count = 25;
    endtask

    // Random: mostly meaningful traffic built around the car, some noise
    task automatic run_random();
        int            pick;
        els_pkg::cmd_t cmd;
        logic [3:0]    floor;
        while (random_count < RandomGoal) begin
            if (random_count % 150 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (random_count >= RandomGoal - QuietTail)
                idle_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                cmd   = els_pkg::CMD_REQUEST;
                floor = 4'($urandom_range(1, els_pkg::NumFloorsDefault));
            end else if (pick < 65) begin
                cmd   = els_pkg::CMD_TICK;
                floor = 4'($urandom_range(0, 15));
            end else if (pick < 85) begin
                cmd   = $urandom_range(0, 1) ? els_pkg::CMD_BOARD : els_pkg::CMD_ALIGHT;
                floor = car_board.car_at;
            end else if (pick < 93) begin
                cmd   = $urandom_range(0, 1) ? els_pkg::CMD_BOARD : els_pkg::CMD_ALIGHT;
                floor = 4'($urandom_range(0, 15));
            end else begin
                cmd   = els_pkg::CMD_REQUEST;
                floor = 4'($urandom_range(0, 15));
            end
            send_command(cmd, floor);
            random_count++;
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        run_random();
        s_axis_tvalid <= 1'b0;
        while (car_board.reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (car_board.reports.size() != 0) begin
            $error("%0d reports never arrived", car_board.reports.size());
            car_board.mismatches++;
        end
        $display("Ran %0d directed and %0d random commands through the LOOK car,",
                 directed_count, random_count);
        $display("with %0d reports checked field by field.", car_board.checked);
        if (car_board.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/els_pkg.sv
src/els_step.sv
src/elevator_look_scheduler.sv
test/tb_elevator_look_scheduler.sv
